/* rtl/hufdec_pkg.sv */
// ----------------------------------------------------------------------------
// hufdec_pkg
// Shared request codes and result queue sizing for the tree-walk decoder.
// ----------------------------------------------------------------------------
package hufdec_pkg;

    // Request kinds carried on the slave tuser bit.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BIT  = 1'b1;

    // Result queue between the walk logic and the master side.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

endpackage

/* rtl/huffman_tree_bit_decoder_unit.sv */
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_unit
// Bit-serial Huffman decoder walking a code tree held in an on-chip node table.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser selects the request kind. A load request writes one
//   node (leaf flag, symbol, left and right child) and returns the walk to the
//   root. A bit request steps to the left child for 0 or the right child for 1.
//   Master stream: one symbol each time the walk reaches a leaf.
//   Config: i_cfg_wr_en writes the root node index; the new root is used on
//   the next return to the root.
// Throughput: one request per cycle, sustained while the result queue has room. The node table has a single
//   synchronous read port for the child lookup, and the record it returns is
//   forwarded straight into the next step, so one table read per bit sets the
//   pace. A second read port keeps the root record at hand.
// Result path: a bit at a leaf root yields its symbol on the master side
//   in the cycle after the request; a leaf landing waits on the child read first.
// Reset: the walk returns to the root, the root index is 0 and the result
//   queue is empty. Node table contents are undefined until loaded.
// Stall: results wait in a four-entry queue; the slave side drops tready once
//   the queue cannot take the results still in flight.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_unit #(
    parameter int NODE_COUNT  = 512,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    // Root node register.
    input  logic                                              i_cfg_wr_en,
    input  logic [$clog2(NODE_COUNT)-1:0]                     i_cfg_wr_data,
    // Request stream.
    input  logic                                              i_s_axis_tvalid,
    output logic                                              o_s_axis_tready,
    // tdata, low bit up: node_index, node_is_leaf, node_symbol, left_index,
    // right_index, code_bit, zero fill.
    input  logic [((3*$clog2(NODE_COUNT)+SYMBOL_BITS+2+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: op.
    input  logic                                              i_s_axis_tuser,
    // Result stream.
    output logic                                              o_m_axis_tvalid,
    input  logic                                              i_m_axis_tready,
    // tdata, low bit up: symbol, zero fill.
    output logic [((SYMBOL_BITS+7)/8)*8-1:0]                  o_m_axis_tdata
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int OUT_W = ((SYMBOL_BITS + 7) / 8) * 8;
    localparam logic [IDX_W:0] NODE_LIM = (IDX_W + 1)'(NODE_COUNT);

    // Field offsets inside the request tdata.
    localparam int LEAF_POS  = IDX_W;
    localparam int SYM_POS   = IDX_W + 1;
    localparam int LEFT_POS  = SYM_POS + SYMBOL_BITS;
    localparam int RIGHT_POS = LEFT_POS + IDX_W;
    localparam int BIT_POS   = RIGHT_POS + IDX_W;

    typedef struct packed {
        logic                   leaf;
        logic [SYMBOL_BITS-1:0] sym;
        logic [IDX_W-1:0]       left;
        logic [IDX_W-1:0]       right;
    } t_node;

    // Bring an index into the table range; one subtract suffices because
    // any IDX_W-bit value is below twice the node count.
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] v);
        logic [IDX_W:0] w;
        w = {1'b0, v};
        if (w >= NODE_LIM) begin
            w = w - NODE_LIM;
        end
        return w[IDX_W-1:0];
    endfunction

    // Node table and its registered read ports.
    t_node mem [NODE_COUNT];
    t_node r_rd_a;
    t_node r_rd_b;

    // Walk state.
    logic [IDX_W-1:0] r_root;
    logic             r_started;
    logic             r_pend;
    t_node            r_cur;
    logic             n_started;
    logic             n_pend;

    // Last table write, kept to forward into the root read port.
    logic             r_wr_valid;
    logic [IDX_W-1:0] r_wr_idx;
    t_node            r_wr_rec;

    // Result queue.
    logic [SYMBOL_BITS-1:0]           r_q [hufdec_pkg::OUT_DEPTH];
    logic [hufdec_pkg::OUT_PTR_W-1:0] r_wp;
    logic [hufdec_pkg::OUT_PTR_W-1:0] r_rp;
    logic [hufdec_pkg::OUT_CNT_W-1:0] r_cnt;
    logic [hufdec_pkg::OUT_CNT_W-1:0] n_cnt;

    logic             acc;
    logic             is_load;
    logic             is_bit;
    logic [IDX_W-1:0] wr_idx;
    t_node            wr_rec;
    logic [IDX_W-1:0] root_rd_idx;
    t_node            root_rec;
    logic             land_leaf;
    logic             eff_started;
    t_node            eff_cur;
    t_node            here;
    logic             root_leaf;
    logic             step;
    logic [IDX_W-1:0] next_idx;
    logic [1:0]       push_cnt;
    logic             pop;
    logic [hufdec_pkg::OUT_PTR_W-1:0] wp_inc;

    // Request decode.
    assign acc     = i_s_axis_tvalid & o_s_axis_tready;
    assign is_load = acc & (i_s_axis_tuser == hufdec_pkg::OP_LOAD);
    assign is_bit  = acc & (i_s_axis_tuser == hufdec_pkg::OP_BIT);

    assign wr_idx       = wrap_idx(i_s_axis_tdata[IDX_W-1:0]);
    assign wr_rec.leaf  = i_s_axis_tdata[LEAF_POS];
    assign wr_rec.sym   = i_s_axis_tdata[SYM_POS +: SYMBOL_BITS];
    assign wr_rec.left  = wrap_idx(i_s_axis_tdata[LEFT_POS +: IDX_W]);
    assign wr_rec.right = wrap_idx(i_s_axis_tdata[RIGHT_POS +: IDX_W]);

    // The root port reads the root that will be current next cycle.
    assign root_rd_idx = i_cfg_wr_en ? wrap_idx(i_cfg_wr_data) : r_root;
    assign root_rec    = (r_wr_valid && (r_wr_idx == r_root)) ? r_wr_rec : r_rd_b;

    // A pending child read resolves this cycle: a leaf ends the walk.
    assign land_leaf   = r_pend & r_rd_a.leaf;
    assign eff_started = r_pend ? ~r_rd_a.leaf : r_started;
    assign eff_cur     = r_pend ? r_rd_a : r_cur;
    assign here        = eff_started ? eff_cur : root_rec;

    // A leaf root answers at once; otherwise step to a child.
    assign root_leaf = is_bit & here.leaf;
    assign step      = is_bit & ~here.leaf;
    assign next_idx  = i_s_axis_tdata[BIT_POS] ? here.right : here.left;

    // A landing from the previous bit and a leaf root on this bit can both
    // give a symbol in the same cycle; the landing symbol is queued first.
    assign push_cnt = {1'b0, land_leaf} + {1'b0, root_leaf};
    assign wp_inc   = r_wp + 1'b1;
    assign pop      = o_m_axis_tvalid & i_m_axis_tready;

    // Next walk state.
    always_comb begin
        n_started = eff_started;
        n_pend    = 1'b0;
        if (is_load || root_leaf) begin
            n_started = 1'b0;
        end else if (step) begin
            n_started = 1'b1;
            n_pend    = 1'b1;
        end
    end

    always_comb begin
        n_cnt = r_cnt + hufdec_pkg::OUT_CNT_W'(push_cnt) - hufdec_pkg::OUT_CNT_W'(pop);
    end

    // Hold off requests while queued plus in-flight results could overflow.
    assign o_s_axis_tready = ((r_cnt + hufdec_pkg::OUT_CNT_W'(r_pend))
                             <= hufdec_pkg::OUT_CNT_W'(hufdec_pkg::OUT_DEPTH - 2));
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = OUT_W'(r_q[r_rp]);

    // Node table: one write port, child and root read ports.
    always_ff @(posedge i_clk) begin
        if (is_load) begin
            mem[wr_idx] <= wr_rec;
        end
        r_rd_a <= mem[next_idx];
        r_rd_b <= mem[root_rd_idx];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur    <= eff_cur;
        r_wr_idx <= wr_idx;
        r_wr_rec <= wr_rec;
        if (land_leaf) begin
            r_q[r_wp] <= r_rd_a.sym;
        end
        if (root_leaf) begin
            r_q[land_leaf ? wp_inc : r_wp] <= here.sym;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root     <= '0;
            r_started  <= 1'b0;
            r_pend     <= 1'b0;
            r_wr_valid <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_root <= wrap_idx(i_cfg_wr_data);
            end
            r_started  <= n_started;
            r_pend     <= n_pend;
            r_wr_valid <= is_load;
            r_wp       <= r_wp + hufdec_pkg::OUT_PTR_W'(push_cnt);
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/hufdec_chk.sv */
// ----------------------------------------------------------------------------
// hufdec_chk
// Port-level checks for the tree-walk decoder, bound to its top level.
// ----------------------------------------------------------------------------
module hufdec_chk #(
    parameter int OUT_W = 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    logic in_acc;

    assign in_acc = i_s_axis_tvalid & o_s_axis_tready;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its symbol.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result symbol changed while stalled");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered right after reset");

    // With nothing queued, requests are never held off.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("requests held off with an empty queue");

    // A new result traces back to a recently accepted request.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(in_acc, 1) || $past(in_acc, 2))
        else $error("result without a recent request");

endmodule

bind huffman_tree_bit_decoder_unit hufdec_chk #(
    .OUT_W(OUT_W)
) u_hufdec_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
